[rtl/core/u8s_pkg.sv]
// Shared types, constants and helpers for the UTF-8 stream sanitizer.
// No dependencies; every other file of the block imports this package.
package u8s_pkg;

	// Character codes used for replacement and filtering
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// Most bytes that one input byte can release
	localparam int unsigned MAX_RESULTS = 4;

	// Default number of bursts buffered between front and back
	localparam int unsigned QUEUE_DEPTH = 4;

	// Upstream transaction: one raw byte
	typedef struct packed {
		logic [7:0] in_byte;
		logic       final_byte;
	} up_item_t;

	// Downstream transaction: one sanitized byte
	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} dn_item_t;

	// All bytes released by one input byte, slot 0 first
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] bytes;
		logic [2:0]                  cnt;
		logic                        fin;
	} burst_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// Sequence length coded in a lead byte, 0 if it is no lead byte
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		priority if (b[7:5] == 3'b110)
			len = 3'd2;
		else if (b[7:4] == 4'b1110)
			len = 3'd3;
		else if (b[7:3] == 5'b11110)
			len = 3'd4;
		else
			len = 3'd0;
		return len;
	endfunction

endpackage

[rtl/core/utf8_stream_sanitizer.sv]
// UTF-8 stream sanitizer, top level.
// Channels: up_valid/up_stall/up_data take one raw byte per transaction with
// a flag on the string's last byte; dn_valid/dn_stall/dn_data give one clean
// byte per transaction, with run_last on the last byte released by an input
// and string_end on the last byte of the string.
// Bytes below 0x20 other than tab, LF and CR become a space. Multibyte
// sequences are held until complete and then released whole; a cut sequence,
// a stray continuation or a byte 0xF8 and above becomes '?'.
// The front takes one input byte per cycle while each releases one byte
// and the queue has room; an input that releases several bytes holds the
// output until all of them have gone out. The output serializer, one byte
// per cycle while dn_stall is low, sets the rate; a QDEPTH-entry burst
// queue decouples it from the input side so the front keeps taking bytes
// meanwhile. Reset clears the open sequence, the queue and the output valid
// flag. When dn_stall is high the output holds; once the queue fills,
// up_stall rises. Depends on u8s_pkg, u8s_front, u8s_queue and u8s_back.
module utf8_stream_sanitizer #(
	parameter int unsigned QDEPTH = u8s_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	output logic              up_stall,
	input  u8s_pkg::up_item_t up_data,
	output logic              dn_valid,
	input  logic              dn_stall,
	output u8s_pkg::dn_item_t dn_data
);
	import u8s_pkg::*;

	logic     q_push;
	logic     q_pop;
	burst_t   wr_burst;
	burst_t   rd_burst;
	q_stat_t  q_stat;

	// Classify input bytes
	u8s_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (up_valid),
		.up_stall (up_stall),
		.up_data  (up_data),
		.q_stat   (q_stat),
		.push     (q_push),
		.burst    (wr_burst)
	);

	// Buffer bursts
	u8s_queue #(
		.QDEPTH (QDEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_burst (wr_burst),
		.pop      (q_pop),
		.rd_burst (rd_burst),
		.q_stat   (q_stat)
	);

	// Serialize bursts to the output
	u8s_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (rd_burst),
		.q_stat   (q_stat),
		.pop      (q_pop),
		.dn_valid (dn_valid),
		.dn_stall (dn_stall),
		.dn_data  (dn_data)
	);

`ifndef SYNTHESIS
	// Never push into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("burst pushed into full queue");

	// Every queued burst carries one to four bytes
	a_burst_len: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (wr_burst.cnt != 3'd0 && wr_burst.cnt <= 3'd4))
		else $error("queued burst has bad length");

	// String end only closes the run of an input
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dn_valid && dn_data.string_end) |-> dn_data.run_last)
		else $error("string_end without run_last");
`endif

endmodule

[rtl/core/u8s_front.sv]
// Front end: accepts raw bytes, tracks the open multibyte sequence and
// builds one burst of released bytes per input. Depends on u8s_pkg.
module u8s_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_stall,
	input  u8s_pkg::up_item_t  up_data,
	input  u8s_pkg::q_stat_t   q_stat,
	output logic               push,
	output u8s_pkg::burst_t    burst
);
	import u8s_pkg::*;

	logic [7:0] lead_q;
	logic [7:0] cont_q [2];
	logic [1:0] hcnt_q;
	logic [2:0] slen_q;

	logic [7:0] lead_n;
	logic [1:0] hcnt_n;
	logic [2:0] slen_n;
	logic       cont_we;
	logic       accept;

	// Hold off upstream while the queue has no room
	assign up_stall = q_stat.full;
	assign accept   = up_valid && !up_stall;

	// Classify the byte and build the burst and next sequence state
	always_comb begin
		logic [7:0] b;
		logic       fin;
		logic       is_cont;
		logic [2:0] len;
		logic [7:0] fresh_val;
		logic       fresh_emit;
		logic       fresh_hold;
		logic [2:0] nq;

		b   = up_data.in_byte;
		fin = up_data.final_byte;
		is_cont = (b[7:6] == 2'b10);
		len = lead_len(b);

		// Treatment of a byte outside any open sequence
		fresh_val  = CH_QMARK;
		fresh_emit = 1'b1;
		fresh_hold = 1'b0;
		if (!b[7]) begin
			if (b < CH_SPACE && b != CH_LF && b != CH_CR && b != CH_TAB)
				fresh_val = CH_SPACE;
			else
				fresh_val = b;
		end else if (len != 3'd0 && !fin) begin
			fresh_emit = 1'b0;
			fresh_hold = 1'b1;
		end

		burst.bytes = {MAX_RESULTS{CH_QMARK}};
		burst.cnt   = 3'd0;
		burst.fin   = fin;
		lead_n  = lead_q;
		hcnt_n  = hcnt_q;
		slen_n  = slen_q;
		cont_we = 1'b0;
		nq      = {1'b0, hcnt_q} + 3'd1;

		if (slen_q != 3'd0 && is_cont) begin
			if ({1'b0, hcnt_q} + 3'd2 == slen_q) begin
				// Sequence complete: release it unchanged
				burst.bytes[0] = lead_q;
				burst.bytes[1] = (hcnt_q != 2'd0) ? cont_q[0] : b;
				burst.bytes[2] = (hcnt_q == 2'd2) ? cont_q[1] : b;
				burst.bytes[3] = b;
				burst.cnt = {1'b0, hcnt_q} + 3'd2;
				slen_n = 3'd0;
				hcnt_n = 2'd0;
				lead_n = 8'h00;
			end else begin
				// Hold the continuation; a string end flushes all as '?'
				cont_we = 1'b1;
				hcnt_n  = hcnt_q + 2'd1;
				if (fin)
					burst.cnt = {1'b0, hcnt_q} + 3'd2;
			end
		end else if (slen_q != 3'd0) begin
			// Cut short: '?' for lead and held bytes, then the byte afresh
			burst.bytes[nq[1:0]] = fresh_val;
			burst.cnt = nq + {2'b00, fresh_emit};
			lead_n = fresh_hold ? b : 8'h00;
			hcnt_n = 2'd0;
			slen_n = fresh_hold ? len : 3'd0;
		end else begin
			burst.bytes[0] = fresh_val;
			burst.cnt = {2'b00, fresh_emit};
			if (fresh_hold) begin
				lead_n = b;
				hcnt_n = 2'd0;
				slen_n = len;
			end
		end

		// String end closes any sequence
		if (fin) begin
			lead_n = 8'h00;
			hcnt_n = 2'd0;
			slen_n = 3'd0;
		end
	end

	// Queue only bursts that carry bytes
	assign push = accept && (burst.cnt != 3'd0);

	// Advance sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q <= 8'h00;
			hcnt_q <= 2'd0;
			slen_q <= 3'd0;
		end else if (accept) begin
			lead_q <= lead_n;
			hcnt_q <= hcnt_n;
			slen_q <= slen_n;
		end
	end

	// Store continuation bytes
	always_ff @(posedge clk) begin
		if (accept && cont_we)
			cont_q[hcnt_q[0]] <= up_data.in_byte;
	end

endmodule

[rtl/core/u8s_queue.sv]
// Short burst queue between front and back ends.
// Depends on u8s_pkg for the burst and status types.
module u8s_queue #(
	parameter int unsigned QDEPTH = u8s_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  u8s_pkg::burst_t   wr_burst,
	input  logic              pop,
	output u8s_pkg::burst_t   rd_burst,
	output u8s_pkg::q_stat_t  q_stat
);
	import u8s_pkg::*;

	localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned CW = $clog2(QDEPTH + 1);

	burst_t          mem_q [QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign q_stat.full  = (count_q == CW'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign rd_burst     = mem_q[rd_ptr_q];

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_burst;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/core/u8s_back.sv]
// Back end: unpacks queued bursts into single bytes and drives the
// registered output channel. Depends on u8s_pkg.
module u8s_back (
	input  logic              clk,
	input  logic              arst_n,
	input  u8s_pkg::burst_t   head,
	input  u8s_pkg::q_stat_t  q_stat,
	output logic              pop,
	output logic              dn_valid,
	input  logic              dn_stall,
	output u8s_pkg::dn_item_t dn_data
);
	import u8s_pkg::*;

	burst_t    cur_q;
	logic      cur_valid_q;
	logic [1:0] idx_q;
	logic      out_valid_q;
	dn_item_t  out_data_q;

	logic      advance;
	logic      cur_last;

	assign advance  = !out_valid_q || !dn_stall;
	assign cur_last = ({1'b0, idx_q} + 3'd1 == cur_q.cnt);
	assign pop      = !q_stat.empty && (!cur_valid_q || (advance && cur_last));

	assign dn_valid = out_valid_q;
	assign dn_data  = out_data_q;

	// Load the next burst and step through its bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= cur_valid_q;
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (advance && cur_valid_q) begin
				idx_q <= idx_q + 2'd1;
				if (cur_last)
					cur_valid_q <= 1'b0;
			end
		end
	end

	// Hold the burst and output payload
	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (advance && cur_valid_q) begin
			out_data_q.out_byte   <= cur_q.bytes[idx_q];
			out_data_q.run_last   <= cur_last;
			out_data_q.string_end <= cur_last && cur_q.fin;
		end
	end

endmodule

[test/utf8_stream_sanitizer_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for utf8_stream_sanitizer: predicts the cleaned bytes of every
// accepted input transaction and compares output transactions in order.
// Depends on u8s_pkg for the channel structs and the character codes.
module utf8_stream_sanitizer_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              up_valid,
	input  logic              up_stall,
	input  u8s_pkg::up_item_t up_data,
	input  logic              dn_valid,
	input  logic              dn_stall,
	input  u8s_pkg::dn_item_t dn_data,
	output int                mismatch_count,
	output int                bytes_due
);
	import u8s_pkg::*;

	// Open multibyte sequence as the predictor sees it
	logic [7:0] open_lead;
	logic [7:0] open_tail [2];
	int         tail_cnt;
	int         open_len;

	// Bytes released by the transaction being predicted
	logic [7:0] released [4];
	int         released_n;

	// Cleaned bytes still to come out, oldest first
	dn_item_t   clean_bytes_due [$];

	function automatic int coded_length(input logic [7:0] b);
		if ((b & 8'hE0) == 8'hC0)
			return 2;
		if ((b & 8'hF0) == 8'hE0)
			return 3;
		if ((b & 8'hF8) == 8'hF0)
			return 4;
		return 0;
	endfunction

	task automatic release_byte(input logic [7:0] b);
		if (released_n < 4) begin
			released[released_n] = b;
			released_n++;
		end
	endtask

	task automatic close_sequence();
		open_lead = 8'h00;
		tail_cnt  = 0;
		open_len  = 0;
	endtask

	// Replace the lead and every held continuation with '?'
	task automatic reject_sequence();
		release_byte(CH_QMARK);
		for (int k = 0; k < tail_cnt && k < 2; k++)
			release_byte(CH_QMARK);
		close_sequence();
	endtask

	// Handle a byte with no sequence open
	task automatic take_fresh(input logic [7:0] b, input logic fin);
		int len;
		if (b < 8'h80) begin
			if (b < 8'h20 && b != CH_LF && b != CH_CR && b != CH_TAB)
				release_byte(CH_SPACE);
			else
				release_byte(b);
			return;
		end
		len = coded_length(b);
		if (len == 0 || fin) begin
			release_byte(CH_QMARK);
			return;
		end
		open_lead = b;
		tail_cnt  = 0;
		open_len  = len;
	endtask

	// Predict the output transactions caused by one input byte
	task automatic sanitize_byte(input up_item_t item);
		logic [7:0] b;
		logic       fin;
		dn_item_t   res;
		b          = item.in_byte;
		fin        = item.final_byte;
		released_n = 0;
		if (open_len != 0) begin
			if (b[7:6] == 2'b10) begin
				if (tail_cnt + 2 == open_len) begin
					release_byte(open_lead);
					for (int k = 0; k < tail_cnt && k < 2; k++)
						release_byte(open_tail[k]);
					release_byte(b);
					close_sequence();
				end else begin
					if (tail_cnt < 2) begin
						open_tail[tail_cnt] = b;
						tail_cnt++;
					end
					if (fin)
						reject_sequence();
				end
			end else begin
				reject_sequence();
				take_fresh(b, fin);
			end
		end else begin
			take_fresh(b, fin);
		end
		if (fin)
			close_sequence();
		for (int k = 0; k < released_n; k++) begin
			res.out_byte   = released[k];
			res.run_last   = (k == released_n - 1);
			res.string_end = (k == released_n - 1) && fin;
			clean_bytes_due = {clean_bytes_due, res};
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: %s: got %h, want %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Compare output first, then predict from input, on every accepting edge
	always @(posedge clk or negedge arst_n) begin
		dn_item_t want;
		if (!arst_n) begin
			close_sequence();
			open_tail[0] = 8'h00;
			open_tail[1] = 8'h00;
			clean_bytes_due.delete();
			mismatch_count = 0;
			bytes_due <= 0;
		end else begin
			if (dn_valid && !dn_stall) begin
				if (clean_bytes_due.size() == 0) begin
					report_mismatch("unexpected output byte", dn_data.out_byte, 8'h00);
				end else begin
					want = clean_bytes_due.pop_front();
					if (dn_data.out_byte !== want.out_byte)
						report_mismatch("out_byte", dn_data.out_byte, want.out_byte);
					if (dn_data.run_last !== want.run_last)
						report_mismatch("run_last", 8'(dn_data.run_last), 8'(want.run_last));
					if (dn_data.string_end !== want.string_end)
						report_mismatch("string_end", 8'(dn_data.string_end),
							8'(want.string_end));
				end
			end
			if (up_valid && !up_stall)
				sanitize_byte(up_data);
			bytes_due <= clean_bytes_due.size();
		end
	end

endmodule

[test/utf8_stream_sanitizer_test.sv]
`timescale 1ns / 1ps
// Top of the utf8_stream_sanitizer testbench: clock, reset, byte strings with
// random idling on both channels, and the verdict.
// Depends on u8s_pkg, the block itself and utf8_stream_sanitizer_checker.
module utf8_stream_sanitizer_test;
	import u8s_pkg::*;

	localparam int RANDOM_ITEMS = 320;

	// Hand-picked opening: controls, complete and cut sequences, stray bytes
	localparam up_item_t OPENING [26] = '{
		'{8'h00, 1'b0}, '{8'h09, 1'b0}, '{8'h0A, 1'b0}, '{8'h0D, 1'b0},
		'{8'h1F, 1'b0}, '{8'h7F, 1'b0}, '{8'h20, 1'b0},
		'{8'hC3, 1'b0}, '{8'hA9, 1'b0},
		'{8'hE2, 1'b0}, '{8'h82, 1'b0}, '{8'hAC, 1'b0},
		'{8'hE2, 1'b0}, '{8'h82, 1'b0}, '{8'h41, 1'b0},
		'{8'h80, 1'b0}, '{8'hFF, 1'b0}, '{8'hF8, 1'b0},
		'{8'hF0, 1'b0}, '{8'h9F, 1'b0}, '{8'h98, 1'b0}, '{8'h80, 1'b1},
		'{8'hF4, 1'b0}, '{8'h8F, 1'b0}, '{8'hBF, 1'b1},
		'{8'hC2, 1'b1}
	};

	logic     clk;
	logic     arst_n;
	logic     up_valid;
	logic     up_stall;
	up_item_t up_data;
	logic     dn_valid;
	logic     dn_stall;
	dn_item_t dn_data;
	int       mismatch_count;
	int       bytes_due;

	// Set while both sides run without idling
	bit       calm;
	up_item_t raw_stream [$];

	utf8_stream_sanitizer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (up_valid),
		.up_stall (up_stall),
		.up_data  (up_data),
		.dn_valid (dn_valid),
		.dn_stall (dn_stall),
		.dn_data  (dn_data)
	);

	utf8_stream_sanitizer_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.up_valid       (up_valid),
		.up_stall       (up_stall),
		.up_data        (up_data),
		.dn_valid       (dn_valid),
		.dn_stall       (dn_stall),
		.dn_data        (dn_data),
		.mismatch_count (mismatch_count),
		.bytes_due      (bytes_due)
	);

	function automatic logic [7:0] continuation_byte();
		return {2'b10, 6'($urandom)};
	endfunction

	function automatic logic [7:0] lead_byte(input int len);
		unique case (len)
			2: return {3'b110, 5'($urandom)};
			3: return {4'b1110, 4'($urandom)};
			default: return {5'b11110, 3'($urandom)};
		endcase
	endfunction

	// Append one string: mostly well-formed characters, some noise and cut ones
	task automatic add_string();
		int         n_chars;
		int         pick;
		int         len;
		int         n_tail;
		logic [7:0] unit [$];
		up_item_t   item;
		n_chars = $urandom_range(1, 10);
		for (int c = 0; c < n_chars; c++) begin
			pick = $urandom_range(0, 99);
			unit.delete();
			if (pick < 30) begin
				unit = {unit, 8'($urandom_range(0, 127))};
			end else if (pick < 75) begin
				len = $urandom_range(2, 4);
				unit = {unit, lead_byte(len)};
				for (int k = 1; k < len; k++)
					unit = {unit, continuation_byte()};
			end else if (pick < 85) begin
				len    = $urandom_range(2, 4);
				n_tail = $urandom_range(0, len - 2);
				unit = {unit, lead_byte(len)};
				for (int k = 0; k < n_tail; k++)
					unit = {unit, continuation_byte()};
			end else if (pick < 95) begin
				unit = {unit, 8'($urandom_range(0, 255))};
			end else begin
				unit = {unit, continuation_byte()};
			end
			for (int k = 0; k < unit.size(); k++) begin
				item.in_byte    = unit[k];
				item.final_byte = (c == n_chars - 1) && (k == unit.size() - 1);
				raw_stream = {raw_stream, item};
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stall the output at random, except in the calm stretch
	initial begin
		dn_stall <= 1'b0;
		forever begin
			@(posedge clk);
			dn_stall <= !calm && ($urandom_range(0, 99) < 14);
		end
	end

	initial begin
		#3000000;
		$display("utf8_stream_sanitizer: mismatch");
		$finish;
	end

	// Feed the strings, then drain and give the verdict
	initial begin
		int idx;
		up_valid <= 1'b0;
		up_data  <= '0;
		foreach (OPENING[i])
			raw_stream = {raw_stream, OPENING[i]};
		while (raw_stream.size() < RANDOM_ITEMS + $size(OPENING))
			add_string();
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		for (idx = 0; idx < raw_stream.size(); idx++) begin
			calm = (idx >= 150 && idx < 230);
			while (!calm && $urandom_range(0, 99) < 14) begin
				up_valid <= 1'b0;
				@(posedge clk);
			end
			up_valid <= 1'b1;
			up_data  <= raw_stream[idx];
			@(posedge clk);
			while (up_stall)
				@(posedge clk);
		end
		up_valid <= 1'b0;
		do
			@(posedge clk);
		while (bytes_due != 0);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && bytes_due == 0)
			$display("utf8_stream_sanitizer: match");
		else
			$display("utf8_stream_sanitizer: mismatch");
		$finish;
	end

endmodule
